@@ rtl/ppc_pkg.sv @@
// Package for the plasma pixel color core: sizes, fixed-point constants, quarter-sine table.
`default_nettype none
package ppc_pkg;

  // image and phase geometry
  localparam int WIDTH      = 128;
  localparam int HEIGHT     = 32;
  localparam int PHASE_BITS = 12;

  // field widths
  localparam int XW    = 7;
  localparam int YW    = 5;
  localparam int FW    = 16;
  localparam int OUT_W = 4;

  // quarter-wave table: entries 0 .. QUARTER inclusive
  localparam int QUARTER   = 1 << (PHASE_BITS - 2);
  localparam int ROM_DEPTH = QUARTER + 1;
  localparam int AW        = PHASE_BITS - 1;

  // Q9.6 terms: 128 + 128*sin
  localparam int MAG_W    = 14;
  localparam int TERM_MID = 8192;
  localparam int TERM_W   = 15;
  localparam int SUM_W    = 17;

  // 1/(2*pi) in Q32, pi/2 in Q30
  localparam int              INV_W  = 30;
  localparam int              INV_Q  = 32;
  localparam logic [INV_W-1:0] INV2PI = 30'd683565276;
  localparam int              Q_FRAC = 30;
  localparam logic [63:0]     PIO2_Q30 = 64'd1686629713;
  localparam logic [63:0]     ONE_Q30  = 64'd1 << Q_FRAC;

  // fraction bits of each argument
  localparam int FRAC_X = 4;
  localparam int FRAC_Y = 3;
  localparam int FRAC_D = 4;
  localparam int FRAC_R = 7;

  // square root: x*x + y*y scaled by 2^8, root in Q.4
  localparam int SQRT_FRAC = 4;
  localparam int SQ_W      = 2 * XW + 1;
  localparam int RW        = (SQ_W + 2 * SQRT_FRAC + 1) / 2;
  localparam int RAD_W     = 2 * RW;
  localparam int REM_W     = RW + 2;
  localparam int SQ_PER    = 3;
  localparam int SQ_STAGES = (RW + SQ_PER - 1) / SQ_PER;

  localparam int PROD_W = RW + INV_W + 1;

  // sum / 3200 = (sum >> 7) / 25, the latter by reciprocal 1311 / 2^15
  localparam int DIV_PRE = 7;
  localparam int QW      = SUM_W - DIV_PRE;
  localparam int DIV_MW  = 11;
  localparam logic [DIV_MW-1:0] DIV_MUL = 11'd1311;
  localparam int DIV_SH  = 15;

  // Taylor series divisors, innermost first
  localparam int TAYLOR_N = 5;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_N] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef logic [MAG_W-1:0] qsin_rom_t [ROM_DEPTH];

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [RW-1:0]    root;
  } ppc_sq_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] px;
    logic [PHASE_BITS-1:0] py;
    logic [PHASE_BITS-1:0] pd;
    logic [OUT_W-1:0]      frame;
  } ppc_side_t;

  typedef struct packed {
    logic          hi;
    logic [AW-1:0] addr;
  } ppc_lane_t;

  // Q13 sine magnitude over the first quadrant, evaluated at elaboration only
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] mag;
    th  = (r * PIO2_Q30) >> (PHASE_BITS - 2);
    t2  = (th * th) >> Q_FRAC;
    acc = ONE_Q30;
    for (int i = 0; i < TAYLOR_N; i++) begin
      d   = ((t2 * acc) >> Q_FRAC) / TAYLOR_DIV[i];
      acc = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    end
    s   = (th * acc) >> Q_FRAC;
    mag = (s * 64'(TERM_MID) + (ONE_Q30 >> 1)) >> Q_FRAC;
    if (mag > 64'(TERM_MID)) begin
      mag = 64'(TERM_MID);
    end
    return MAG_W'(mag);
  endfunction

  function automatic qsin_rom_t build_qsin();
    qsin_rom_t t;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      t[i] = quarter_sine(64'(i));
    end
    return t;
  endfunction

  localparam qsin_rom_t QSIN_ROM = build_qsin();

endpackage
`default_nettype wire

@@ rtl/ppc_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none
module ppc_ram #(
  parameter int DATA_W = 14,
  parameter int DEPTH  = 1025,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ rtl/plasma_pixel_color_core.sv @@
// Plasma pixel color core: pipelined sine-sum palette index per pixel.
`default_nettype none
// Usage
//   Pixel channel: pix_valid / pix_stall with pixel_x, pixel_y, frame_number.
//   A word is taken at a rising edge with pix_valid high and pix_stall low.
//   Color channel: color_valid / color_stall with palette_index.
//   Throughput: one pixel per clock, sustained, as long as color_stall is low and the table load is done.
//   Path: the pixel word is registered with its clamped squares, then the
//   square root is 4 stages of 3 digit steps, then phase/fold, table read,
//   four-term sum and the divide-by-3200 output stage.
//   Reset: synchronous, active high. All stage valids clear, then the two
//   quarter-sine RAMs are loaded from the constant table, one entry per
//   clock, 1025 entries in all; pix_stall stays high until that is done.
//   Stall: color_stall high with a word waiting freezes the whole pipeline;
//   pix_stall follows it the same cycle, so nothing is dropped or repeated.
//   The output register is the last stage, so a new pixel is taken in the
//   same cycle the waiting color word is taken.
//   Coordinates beyond WIDTH-1 / HEIGHT-1 are clamped to the edge.
module plasma_pixel_color_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  logic [ppc_pkg::XW-1:0]    pixel_x,
  input  logic [ppc_pkg::YW-1:0]    pixel_y,
  input  logic [ppc_pkg::FW-1:0]    frame_number,
  output logic                      color_valid,
  input  logic                      color_stall,
  output logic [ppc_pkg::OUT_W-1:0] palette_index
);
  import ppc_pkg::*;

  // one digit step pair per iteration, restoring square root
  function automatic ppc_sq_t sq_steps(input ppc_sq_t s_in, input int stage);
    ppc_sq_t             s;
    logic [REM_W+1:0]    cur;
    logic [REM_W+1:0]    trial;
    s = s_in;
    for (int j = 0; j < SQ_PER; j++) begin
      if (stage * SQ_PER + j < RW) begin
        cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = (REM_W+2)'({s.root, 2'b01});
        if (cur >= trial) begin
          s.rem  = REM_W'(cur - trial);
          s.root = {s.root[RW-2:0], 1'b1};
        end else begin
          s.rem  = REM_W'(cur);
          s.root = {s.root[RW-2:0], 1'b0};
        end
        s.rad = s.rad << 2;
      end
    end
    return s;
  endfunction

  // round(n / 2^frac / (2*pi) * 2^PHASE_BITS) mod 2^PHASE_BITS
  function automatic logic [PHASE_BITS-1:0] phase_of(input logic [RW-1:0] n, input int frac);
    logic [PROD_W-1:0] prod;
    int                sh;
    sh   = INV_Q + frac - PHASE_BITS;
    prod = PROD_W'(n) * PROD_W'(INV2PI) + (PROD_W'(1) << (sh - 1));
    return PHASE_BITS'(prod >> sh);
  endfunction

  // quadrant fold: table address and sign of the sine
  function automatic ppc_lane_t fold(input logic [PHASE_BITS-1:0] ph);
    ppc_lane_t     l;
    logic [AW-1:0] r;
    r      = AW'(ph[PHASE_BITS-3:0]);
    l.hi   = ph[PHASE_BITS-1];
    l.addr = ph[PHASE_BITS-2] ? AW'(QUARTER) - r : r;
    return l;
  endfunction

  logic adv;
  logic accept;

  // table load after reset
  logic          filling;
  logic [AW-1:0] fill_cnt;

  // stage 1
  logic             v1;
  logic [XW-1:0]    x1;
  logic [YW-1:0]    y1;
  logic [XW-1:0]    dmag1;
  logic             dneg1;
  logic [SQ_W-1:0]  sumsq1;
  logic [OUT_W-1:0] frame1;

  // square root stages
  logic [SQ_STAGES-1:0] vsq;
  ppc_sq_t              sq_q [SQ_STAGES];
  ppc_sq_t              sq_d [SQ_STAGES];
  ppc_side_t            side_q [SQ_STAGES];
  ppc_side_t            side_d;

  // stage 6: table addresses
  logic             v6;
  ppc_lane_t        lane6 [4];
  logic [OUT_W-1:0] frame6;

  // stage 7: table data
  logic             v7;
  logic [MAG_W-1:0] mag7 [4];
  logic [3:0]       hi7;
  logic [OUT_W-1:0] frame7;

  // stage 8: sum
  logic             v8;
  logic [SUM_W-1:0] sum8;
  logic [OUT_W-1:0] frame8;

  logic [XW-1:0]    x_cl;
  logic [YW-1:0]    y_cl;
  logic [2*XW-1:0]  x_sq;
  logic [2*YW-1:0]  y_sq;
  logic [PHASE_BITS-1:0] pd_raw;
  logic [PHASE_BITS-1:0] pr;
  ppc_sq_t          sq_init;
  logic [SUM_W-1:0] sum_next;
  logic [QW+DIV_MW-1:0] quot_prod;

  assign adv       = !color_valid || !color_stall;
  assign pix_stall = filling || !adv;
  assign accept    = pix_valid && !pix_stall;

  // table load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      filling  <= 1'b1;
      fill_cnt <= '0;
    end else if (filling) begin
      if (fill_cnt == AW'(QUARTER)) begin
        filling <= 1'b0;
      end else begin
        fill_cnt <= fill_cnt + AW'(1);
      end
    end
  end

  // stage 1 input: clamp, squares, difference
  always_comb begin
    x_cl = (int'(pixel_x) > WIDTH - 1) ? XW'(WIDTH - 1) : pixel_x;
    y_cl = (int'(pixel_y) > HEIGHT - 1) ? YW'(HEIGHT - 1) : pixel_y;
    x_sq = (2*XW)'(x_cl) * (2*XW)'(x_cl);
    y_sq = (2*YW)'(y_cl) * (2*YW)'(y_cl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1     <= x_cl;
      y1     <= y_cl;
      dneg1  <= XW'(y_cl) > x_cl;
      dmag1  <= (XW'(y_cl) > x_cl) ? XW'(y_cl) - x_cl : x_cl - XW'(y_cl);
      sumsq1 <= SQ_W'(x_sq) + SQ_W'(y_sq);
      frame1 <= frame_number[OUT_W-1:0];
    end
  end

  // stage 2 input: three phases, first root digits
  always_comb begin
    pd_raw       = phase_of(RW'(dmag1), FRAC_D);
    side_d.px    = phase_of(RW'(x1), FRAC_X);
    side_d.py    = phase_of(RW'(y1), FRAC_Y);
    side_d.pd    = dneg1 ? PHASE_BITS'(0) - pd_raw : pd_raw;
    side_d.frame = frame1;
    sq_init.rad  = RAD_W'(sumsq1) << (2 * SQRT_FRAC);
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_d[0]      = sq_steps(sq_init, 0);
    for (int i = 1; i < SQ_STAGES; i++) begin
      sq_d[i] = sq_steps(sq_q[i-1], i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vsq <= '0;
    end else if (adv) begin
      vsq <= {vsq[SQ_STAGES-2:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 0; i < SQ_STAGES; i++) begin
        sq_q[i] <= sq_d[i];
      end
      for (int i = 1; i < SQ_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stage 6: root phase and quadrant folding
  assign pr = phase_of(sq_q[SQ_STAGES-1].root, FRAC_R);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      color_valid <= 1'b0;
    end else if (adv) begin
      v6 <= vsq[SQ_STAGES-1];
      v7 <= v6;
      v8 <= v7;
      color_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane6[0] <= fold(side_q[SQ_STAGES-1].px);
      lane6[1] <= fold(side_q[SQ_STAGES-1].py);
      lane6[2] <= fold(side_q[SQ_STAGES-1].pd);
      lane6[3] <= fold(pr);
      frame6   <= side_q[SQ_STAGES-1].frame;
    end
  end

  // stage 7: quarter-sine lookups, two lanes per RAM
  ppc_ram #(.DATA_W(MAG_W), .DEPTH(ROM_DEPTH)) u_ram_xy (
    .clk     (clk),
    .we      (filling),
    .waddr   (fill_cnt),
    .wdata   (QSIN_ROM[fill_cnt]),
    .re      (adv),
    .raddr_a (lane6[0].addr),
    .raddr_b (lane6[1].addr),
    .rdata_a (mag7[0]),
    .rdata_b (mag7[1])
  );

  ppc_ram #(.DATA_W(MAG_W), .DEPTH(ROM_DEPTH)) u_ram_dr (
    .clk     (clk),
    .we      (filling),
    .waddr   (fill_cnt),
    .wdata   (QSIN_ROM[fill_cnt]),
    .re      (adv),
    .raddr_a (lane6[2].addr),
    .raddr_b (lane6[3].addr),
    .rdata_a (mag7[2]),
    .rdata_b (mag7[3])
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      hi7    <= {lane6[3].hi, lane6[2].hi, lane6[1].hi, lane6[0].hi};
      frame7 <= frame6;
    end
  end

  // stage 8: four Q9.6 terms summed
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < 4; i++) begin
      sum_next = sum_next + SUM_W'(hi7[i] ? TERM_W'(TERM_MID) - TERM_W'(mag7[i])
                                          : TERM_W'(TERM_MID) + TERM_W'(mag7[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum8   <= sum_next;
      frame8 <= frame7;
    end
  end

  // output: frame + floor(sum / 3200), mod 16
  assign quot_prod = (QW+DIV_MW)'(sum8[SUM_W-1:DIV_PRE]) * (QW+DIV_MW)'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (adv) begin
      palette_index <= frame8 + quot_prod[DIV_SH +: OUT_W];
    end
  end

`ifndef SYNTHESIS
  // a held output freezes every stage
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=> $stable(v1) && $stable(vsq) && $stable(v6)
                                   && $stable(v7) && $stable(v8))
    else $error("pipeline moved while output stalled");

  // nothing in flight while the table is loading
  a_fill_empty: assert property (@(posedge clk) disable iff (rst)
    filling |-> !v1 && (vsq == '0) && !v6 && !v7 && !v8 && !color_valid)
    else $error("item in pipeline during table load");

  // folded addresses stay inside the quarter table
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    v6 |-> (lane6[0].addr <= AW'(QUARTER)) && (lane6[1].addr <= AW'(QUARTER))
           && (lane6[2].addr <= AW'(QUARTER)) && (lane6[3].addr <= AW'(QUARTER)))
    else $error("table address out of range");

  // table data never exceeds full scale
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    v7 |-> (mag7[0] <= MAG_W'(TERM_MID)) && (mag7[1] <= MAG_W'(TERM_MID))
           && (mag7[2] <= MAG_W'(TERM_MID)) && (mag7[3] <= MAG_W'(TERM_MID)))
    else $error("sine magnitude above full scale");
`endif

endmodule
`default_nettype wire
